### sv/acc_cpu_pkg.sv
// Shared types, sizes and instruction codes of the accumulator machine.
package acc_cpu_pkg;

   // Memory and register file sizes.
   localparam int MEM_ADDR_BITS = 16;
   localparam int MEM_SIZE      = 1 << MEM_ADDR_BITS;
   localparam int REG_COUNT     = 8;
   localparam int REG_IDX_W     = $clog2(REG_COUNT);

   // Widest address that any source can form: bank byte above a 12-bit operand.
   localparam int ADDR_EXT_W    = 20;
   localparam int OPERAND_W     = 12;

   // Register roles.
   localparam logic [REG_IDX_W-1:0] REG_IO   = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_BANK = REG_IDX_W'(1);

   // Request commands.
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_STEP    = 1'b1;

   // Instruction opcodes, held in the top four bits of the instruction word.
   typedef enum logic [3:0] {
      OP_ADD_REG     = 4'h0,
      OP_ADD_IMM     = 4'h1,
      OP_AND_REG     = 4'h2,
      OP_OR_REG      = 4'h3,
      OP_XOR_REG     = 4'h4,
      OP_NOT         = 4'h5,
      OP_ROR         = 4'h6,
      OP_STORE_REG   = 4'h7,
      OP_LOAD_REG    = 4'h8,
      OP_STORE_MEM   = 4'h9,
      OP_LOAD_MEM    = 4'hA,
      OP_LOAD_IMM    = 4'hB,
      OP_JUMP        = 4'hC,
      OP_JUMP_ZERO   = 4'hD,
      OP_JUMP_CARRY  = 4'hE,
      OP_CLEAR_CARRY = 4'hF
   } opcode_type;

   // One request: a memory byte load or one instruction step.
   typedef struct packed {
      logic        command;
      logic [15:0] load_address;
      logic [7:0]  load_data;
   } req_type;

   // One response: machine state after the request.
   typedef struct packed {
      logic [7:0]  accumulator_value;
      logic        carry_flag;
      logic [15:0] next_ip;
      logic [7:0]  io_value;
      logic        io_changed;
   } rsp_type;

   // Reduce a wide address to the memory index (wraps at the memory size).
   function automatic logic [MEM_ADDR_BITS-1:0] to_mem_addr(input logic [ADDR_EXT_W-1:0] a);
      return a[MEM_ADDR_BITS-1:0];
   endfunction

endpackage

### sv/accumulator_cpu_step_top.sv
// Accumulator machine: request buffer, single-port byte memory, execute sequencer.
// A step runs the idle, fetch-low and execute states, and a memory-read state for a banked
// load; the single memory port serves two instruction byte reads and any banked data access.
// A load is written and answered from the idle state once the response register is free;
// the request buffer refills the cycle after it empties. After reset the memory is cleared
// one byte a cycle with req_ready low; registers reset at once (register one to one).
module accumulator_cpu_step_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  acc_cpu_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output acc_cpu_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH_LO,
      ST_EXEC,
      ST_MEM_READ
   } state_type;

   state_type state_ff;

   // Architectural state.
   logic [7:0]  acc_ff;
   logic        carry_ff;
   logic [15:0] ip_ff;
   logic [7:0]  regs_ff [acc_cpu_pkg::REG_COUNT];

   // Request buffer and response register.
   acc_cpu_pkg::req_type buf_ff;
   logic                 buf_valid_ff;
   acc_cpu_pkg::rsp_type rsp_ff;
   logic                 rsp_valid_ff;

   // Clearing pass counter and fetched high instruction byte.
   logic [acc_cpu_pkg::MEM_ADDR_BITS-1:0] clr_cnt_ff;
   logic [7:0]                            hi_ff;

   // Memory port.
   logic [7:0]                            mem_array [acc_cpu_pkg::MEM_SIZE];
   logic [7:0]                            mem_rdata_ff;
   logic                                  mem_en;
   logic                                  mem_we;
   logic [acc_cpu_pkg::MEM_ADDR_BITS-1:0] mem_addr;
   logic [7:0]                            mem_wdata;

   // Decode and execute results.
   logic                                  out_free;
   logic                                  rsp_load;
   acc_cpu_pkg::opcode_type               opcode;
   logic [acc_cpu_pkg::OPERAND_W-1:0]     operand;
   logic                                  reg_ok;
   logic [7:0]                            reg_val;
   logic [7:0]                            add_b;
   logic [8:0]                            sum9;
   logic [acc_cpu_pkg::ADDR_EXT_W-1:0]    bank_sum;
   logic [acc_cpu_pkg::ADDR_EXT_W-1:0]    ip_ext;
   logic [acc_cpu_pkg::ADDR_EXT_W-1:0]    ip1_ext;
   logic [acc_cpu_pkg::ADDR_EXT_W-1:0]    load_ext;
   logic [15:0]                           ip_seq;
   logic [7:0]                            acc_in;
   logic                                  carry_in;
   logic [15:0]                           ip_in;
   logic                                  reg_we;
   logic [7:0]                            io_in;
   logic                                  io_changed_in;

   assign req_ready = buf_valid_ff == 1'b0 && state_ff != ST_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The response register takes a new response in this cycle.
   assign rsp_load = out_free &&
                     ((state_ff == ST_IDLE && buf_valid_ff &&
                       buf_ff.command == acc_cpu_pkg::CMD_LOAD) ||
                      (state_ff == ST_EXEC && opcode != acc_cpu_pkg::OP_LOAD_MEM) ||
                      state_ff == ST_MEM_READ);

   // Instruction fields: high byte was captured, low byte is on the memory output.
   assign opcode  = acc_cpu_pkg::opcode_type'(hi_ff[7:4]);
   assign operand = {hi_ff[3:0], mem_rdata_ff};

   // Register file read; indexes past the file read zero.
   assign reg_ok  = operand < acc_cpu_pkg::OPERAND_W'(acc_cpu_pkg::REG_COUNT);
   assign reg_val = reg_ok ? regs_ff[operand[acc_cpu_pkg::REG_IDX_W-1:0]] : 8'h00;

   // Adder with carry in, shared by both add opcodes.
   assign add_b = (opcode == acc_cpu_pkg::OP_ADD_IMM) ? operand[7:0] : reg_val;
   assign sum9  = {1'b0, acc_ff} + {1'b0, add_b} + {8'h00, carry_ff};

   // Addresses: banked data, both fetch bytes and load address.
   assign bank_sum = {regs_ff[acc_cpu_pkg::REG_BANK], 12'h000} + {8'h00, operand};
   assign ip_ext   = {4'h0, ip_ff};
   assign ip1_ext  = ip_ext + 20'd1;
   assign load_ext = {4'h0, buf_ff.load_address};
   assign ip_seq   = ip_ff + 16'd2;

   // Execute one instruction word.
   always_comb begin
      acc_in   = acc_ff;
      carry_in = carry_ff;
      ip_in    = ip_seq;
      reg_we   = 1'b0;
      case (opcode)
         acc_cpu_pkg::OP_ADD_REG, acc_cpu_pkg::OP_ADD_IMM: begin
            acc_in   = sum9[7:0];
            carry_in = sum9[8];
         end
         acc_cpu_pkg::OP_AND_REG:   acc_in = acc_ff & reg_val;
         acc_cpu_pkg::OP_OR_REG:    acc_in = acc_ff | reg_val;
         acc_cpu_pkg::OP_XOR_REG:   acc_in = acc_ff ^ reg_val;
         acc_cpu_pkg::OP_NOT:       acc_in = ~acc_ff;
         acc_cpu_pkg::OP_ROR:       acc_in = {acc_ff[0], acc_ff[7:1]};
         acc_cpu_pkg::OP_STORE_REG: reg_we = reg_ok;
         acc_cpu_pkg::OP_LOAD_REG:  acc_in = reg_val;
         acc_cpu_pkg::OP_LOAD_IMM:  acc_in = operand[7:0];
         acc_cpu_pkg::OP_JUMP:      ip_in = {4'h0, operand};
         acc_cpu_pkg::OP_JUMP_ZERO: begin
            if (acc_ff == 8'h00) begin
               ip_in = {4'h0, operand};
            end
         end
         acc_cpu_pkg::OP_JUMP_CARRY: begin
            if (carry_ff) begin
               ip_in = {4'h0, operand};
            end
         end
         acc_cpu_pkg::OP_CLEAR_CARRY: carry_in = 1'b0;
         default: begin
            // Banked memory moves act on the memory port only.
            acc_in = acc_ff;
         end
      endcase
      io_changed_in = reg_we && operand == acc_cpu_pkg::OPERAND_W'(acc_cpu_pkg::REG_IO) &&
                      acc_ff != regs_ff[acc_cpu_pkg::REG_IO];
      io_in = (reg_we && operand == acc_cpu_pkg::OPERAND_W'(acc_cpu_pkg::REG_IO)) ?
              acc_ff : regs_ff[acc_cpu_pkg::REG_IO];
   end

   // Memory port control by sequencer state.
   always_comb begin
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = '0;
      mem_wdata = 8'h00;
      case (state_ff)
         ST_CLEAR: begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
         end
         ST_IDLE: begin
            if (buf_valid_ff && buf_ff.command == acc_cpu_pkg::CMD_STEP) begin
               mem_en   = 1'b1;
               mem_addr = acc_cpu_pkg::to_mem_addr(ip_ext);
            end else if (buf_valid_ff && out_free) begin
               mem_en    = 1'b1;
               mem_we    = 1'b1;
               mem_addr  = acc_cpu_pkg::to_mem_addr(load_ext);
               mem_wdata = buf_ff.load_data;
            end
         end
         ST_FETCH_LO: begin
            mem_en   = 1'b1;
            mem_addr = acc_cpu_pkg::to_mem_addr(ip1_ext);
         end
         ST_EXEC: begin
            if (opcode == acc_cpu_pkg::OP_LOAD_MEM) begin
               mem_en   = 1'b1;
               mem_addr = acc_cpu_pkg::to_mem_addr(bank_sum);
            end else if (opcode == acc_cpu_pkg::OP_STORE_MEM && out_free) begin
               mem_en    = 1'b1;
               mem_we    = 1'b1;
               mem_addr  = acc_cpu_pkg::to_mem_addr(bank_sum);
               mem_wdata = acc_ff;
            end
         end
         default: begin
            mem_en = 1'b0;
         end
      endcase
   end

   // Single-port byte memory; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            mem_array[mem_addr] <= mem_wdata;
         end else begin
            mem_rdata_ff <= mem_array[mem_addr];
         end
      end
   end

   // Sequencer, machine state, request buffer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 8'h00;
         carry_ff     <= 1'b0;
         ip_ff        <= 16'h0000;
         for (int i = 0; i < acc_cpu_pkg::REG_COUNT; i++) begin
            regs_ff[i[acc_cpu_pkg::REG_IDX_W-1:0]] <=
               (i == int'(acc_cpu_pkg::REG_BANK)) ? 8'h01 : 8'h00;
         end
      end else begin
         // Buffer a new request while the sequencer works.
         if (req_valid && req_ready) begin
            buf_ff       <= req_data;
            buf_valid_ff <= 1'b1;
         end
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + acc_cpu_pkg::MEM_ADDR_BITS'(1);
               if (&clr_cnt_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (buf_valid_ff && buf_ff.command == acc_cpu_pkg::CMD_STEP) begin
                  buf_valid_ff <= 1'b0;
                  state_ff     <= ST_FETCH_LO;
               end else if (buf_valid_ff && out_free) begin
                  // Load request: state unchanged in the response.
                  buf_valid_ff             <= 1'b0;
                  rsp_valid_ff             <= 1'b1;
                  rsp_ff.accumulator_value <= acc_ff;
                  rsp_ff.carry_flag        <= carry_ff;
                  rsp_ff.next_ip           <= ip_ff;
                  rsp_ff.io_value          <= regs_ff[acc_cpu_pkg::REG_IO];
                  rsp_ff.io_changed        <= 1'b0;
               end
            end
            ST_FETCH_LO: begin
               hi_ff    <= mem_rdata_ff;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (opcode == acc_cpu_pkg::OP_LOAD_MEM) begin
                  state_ff <= ST_MEM_READ;
               end else if (out_free) begin
                  acc_ff   <= acc_in;
                  carry_ff <= carry_in;
                  ip_ff    <= ip_in;
                  if (reg_we) begin
                     regs_ff[operand[acc_cpu_pkg::REG_IDX_W-1:0]] <= acc_ff;
                  end
                  rsp_valid_ff             <= 1'b1;
                  rsp_ff.accumulator_value <= acc_in;
                  rsp_ff.carry_flag        <= carry_in;
                  rsp_ff.next_ip           <= ip_in;
                  rsp_ff.io_value          <= io_in;
                  rsp_ff.io_changed        <= io_changed_in;
                  state_ff                 <= ST_IDLE;
               end
            end
            ST_MEM_READ: begin
               // Banked load: data arrives in the cycle after the read.
               if (out_free) begin
                  acc_ff                   <= mem_rdata_ff;
                  ip_ff                    <= ip_seq;
                  rsp_valid_ff             <= 1'b1;
                  rsp_ff.accumulator_value <= mem_rdata_ff;
                  rsp_ff.carry_flag        <= carry_ff;
                  rsp_ff.next_ip           <= ip_seq;
                  rsp_ff.io_value          <= regs_ff[acc_cpu_pkg::REG_IO];
                  rsp_ff.io_changed        <= 1'b0;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### dv/tb_accumulator_cpu_step_top.sv
// Testbench for the accumulator machine: directed and random programs checked against a predictor.
module tb_accumulator_cpu_step_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES    = 11;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   acc_cpu_pkg::req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   acc_cpu_pkg::rsp_type rsp_data;

   // Machine image kept by the predictor.
   logic [7:0]  mem_image [acc_cpu_pkg::MEM_SIZE];
   logic [7:0]  reg_image [acc_cpu_pkg::REG_COUNT];
   logic [7:0]  acc_model;
   logic [15:0] ip_model;
   logic        carry_model;

   // Machine states still to be seen on the response channel, oldest first.
   acc_cpu_pkg::rsp_type pending_states [$];
   acc_cpu_pkg::rsp_type oldest_state;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned requests_accepted = 0;
   int unsigned responses_seen = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   accumulator_cpu_step_top dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data
   );

   // Clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Register read; indexes past the register file read as zero.
   function automatic logic [7:0] reg_value(input logic [11:0] idx);
      return (idx < acc_cpu_pkg::REG_COUNT) ? reg_image[idx] : 8'h00;
   endfunction

   // Byte address of a banked access: bank register above the operand, wrapped.
   function automatic int unsigned bank_address(input logic [11:0] arg);
      return ({reg_image[acc_cpu_pkg::REG_BANK], 12'h000} + arg) % acc_cpu_pkg::MEM_SIZE;
   endfunction

   // Applies one request to the machine image and returns the state it leaves.
   function automatic acc_cpu_pkg::rsp_type machine_step(input acc_cpu_pkg::req_type item);
      acc_cpu_pkg::rsp_type result;
      logic [15:0]          word;
      logic [11:0]          arg;
      logic [7:0]           io_before;
      logic                 jumped;
      io_before = reg_image[acc_cpu_pkg::REG_IO];
      jumped = 1'b0;
      if (item.command == acc_cpu_pkg::CMD_LOAD) begin
         mem_image[item.load_address % acc_cpu_pkg::MEM_SIZE] = item.load_data;
      end else begin
         // Big-endian fetch; the second byte wraps at the top of memory.
         word = {mem_image[ip_model % acc_cpu_pkg::MEM_SIZE],
                 mem_image[(ip_model + 1) % acc_cpu_pkg::MEM_SIZE]};
         arg = word[11:0];
         case (acc_cpu_pkg::opcode_type'(word[15:12]))
            acc_cpu_pkg::OP_ADD_REG:
               {carry_model, acc_model} = acc_model + reg_value(arg) + carry_model;
            acc_cpu_pkg::OP_ADD_IMM:
               {carry_model, acc_model} = acc_model + arg[7:0] + carry_model;
            acc_cpu_pkg::OP_AND_REG:     acc_model = acc_model & reg_value(arg);
            acc_cpu_pkg::OP_OR_REG:      acc_model = acc_model | reg_value(arg);
            acc_cpu_pkg::OP_XOR_REG:     acc_model = acc_model ^ reg_value(arg);
            acc_cpu_pkg::OP_NOT:         acc_model = ~acc_model;
            acc_cpu_pkg::OP_ROR:         acc_model = {acc_model[0], acc_model[7:1]};
            acc_cpu_pkg::OP_STORE_REG: begin
               if (arg < acc_cpu_pkg::REG_COUNT) reg_image[arg] = acc_model;
            end
            acc_cpu_pkg::OP_LOAD_REG:    acc_model = reg_value(arg);
            acc_cpu_pkg::OP_STORE_MEM:   mem_image[bank_address(arg)] = acc_model;
            acc_cpu_pkg::OP_LOAD_MEM:    acc_model = mem_image[bank_address(arg)];
            acc_cpu_pkg::OP_LOAD_IMM:    acc_model = arg[7:0];
            acc_cpu_pkg::OP_JUMP:        jumped = 1'b1;
            acc_cpu_pkg::OP_JUMP_ZERO:   jumped = (acc_model == 8'h00);
            acc_cpu_pkg::OP_JUMP_CARRY:  jumped = carry_model;
            acc_cpu_pkg::OP_CLEAR_CARRY: carry_model = 1'b0;
            default: ;
         endcase
         ip_model = jumped ? {4'h0, arg} : ip_model + 16'd2;
      end
      result.accumulator_value = acc_model;
      result.carry_flag        = carry_model;
      result.next_ip           = ip_model;
      result.io_value          = reg_image[acc_cpu_pkg::REG_IO];
      result.io_changed        = (reg_image[acc_cpu_pkg::REG_IO] != io_before);
      return result;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string text);
      $display("ERROR at %0t: response %0d: %s", $realtime, responses_seen, text);
      error_count++;
   endtask

   task automatic check_field(input string field, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, expected %h", field, got, want));
      end
   endtask

   // Drives one request, holds it until accepted and records the predicted state.
   task automatic send_request(input acc_cpu_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_states.push_back(machine_step(item));
      requests_accepted++;
   endtask

   task automatic load_byte(input logic [15:0] addr, input logic [7:0] data);
      acc_cpu_pkg::req_type item;
      item.command      = acc_cpu_pkg::CMD_LOAD;
      item.load_address = addr;
      item.load_data    = data;
      send_request(item);
   endtask

   // A step request; the load fields are ignored by the block, so they carry noise.
   task automatic step_once();
      acc_cpu_pkg::req_type item;
      item.command      = acc_cpu_pkg::CMD_STEP;
      item.load_address = 16'($urandom);
      item.load_data    = 8'($urandom);
      send_request(item);
   endtask

   task automatic put_instruction(input logic [15:0] addr, input acc_cpu_pkg::opcode_type op,
                                  input logic [11:0] arg);
      load_byte(addr, {op, arg[11:8]});
      load_byte(addr + 16'd1, arg[7:0]);
   endtask

   // Writes one instruction at the pointer and executes it.
   task automatic run_instruction(input acc_cpu_pkg::opcode_type op, input logic [11:0] arg);
      put_instruction(ip_model, op, arg);
      step_once();
   endtask

   // Short program that runs every opcode, the carry jump both taken and not taken.
   // Memory is still clear, so words whose low byte is zero need only their high byte loaded.
   task automatic test_every_opcode();
      send_idle_pct = 0;
      stall_pct = 0;
      // Only the low byte of the immediate counts.
      put_instruction(16'h0000, acc_cpu_pkg::OP_LOAD_IMM, 12'h1A5);
      load_byte(16'h0002, {acc_cpu_pkg::OP_STORE_REG, 4'h0});     // the I/O port changes
      // The word at 0x0004 stays zero: add the I/O port with carry, which overflows.
      load_byte(16'h0006, {acc_cpu_pkg::OP_JUMP_CARRY, 4'h1});    // taken, to 0x0100
      load_byte(16'h0100, {acc_cpu_pkg::OP_NOT, 4'h0});
      load_byte(16'h0102, {acc_cpu_pkg::OP_ROR, 4'h0});
      load_byte(16'h0104, {acc_cpu_pkg::OP_OR_REG, 4'h0});
      load_byte(16'h0106, {acc_cpu_pkg::OP_ADD_IMM, 4'hF});       // zero plus carry wraps to zero
      load_byte(16'h0108, {acc_cpu_pkg::OP_JUMP_ZERO, 4'h2});     // taken, to 0x0200
      load_byte(16'h0200, {acc_cpu_pkg::OP_XOR_REG, 4'h0});
      load_byte(16'h0202, {acc_cpu_pkg::OP_AND_REG, 4'h0});
      load_byte(16'h0204, {acc_cpu_pkg::OP_STORE_MEM, 4'hF});     // bank one, byte 0x1F00
      load_byte(16'h0206, {acc_cpu_pkg::OP_CLEAR_CARRY, 4'h0});
      load_byte(16'h0208, {acc_cpu_pkg::OP_LOAD_REG, 4'hF});      // register index out of range
      load_byte(16'h020A, {acc_cpu_pkg::OP_LOAD_MEM, 4'hF});
      load_byte(16'h020C, {acc_cpu_pkg::OP_JUMP_CARRY, 4'h0});    // not taken
      load_byte(16'h020E, {acc_cpu_pkg::OP_JUMP, 4'h0});          // back to the start
      load_byte(16'hFFFF, 8'hFF);                                 // highest address, all ones
      repeat (17) step_once();
   endtask

   // Moves the bank to the top so a banked store and load wrap past the end of
   // memory, then puts the bank back to one.
   task automatic test_bank_wrap();
      send_idle_pct = 0;
      stall_pct = 0;
      run_instruction(acc_cpu_pkg::OP_LOAD_IMM, 12'h0FF);
      run_instruction(acc_cpu_pkg::OP_STORE_REG, 12'(acc_cpu_pkg::REG_BANK));
      run_instruction(acc_cpu_pkg::OP_LOAD_IMM, 12'h03C);
      run_instruction(acc_cpu_pkg::OP_STORE_MEM, 12'hFFF);
      run_instruction(acc_cpu_pkg::OP_LOAD_IMM, 12'h000);
      run_instruction(acc_cpu_pkg::OP_LOAD_MEM, 12'hFFF);
      run_instruction(acc_cpu_pkg::OP_LOAD_IMM, 12'h001);
      run_instruction(acc_cpu_pkg::OP_STORE_REG, 12'(acc_cpu_pkg::REG_BANK));
   endtask

   // Mostly a random instruction written at the pointer and then executed; the rest
   // are stray loads anywhere and steps through whatever memory holds.
   task automatic test_random_programs(input int unsigned count,
                                       input int unsigned sender_idle,
                                       input int unsigned receiver_stall);
      int unsigned             first;
      int unsigned             choice;
      acc_cpu_pkg::opcode_type op;
      logic [11:0]             arg;
      send_idle_pct = sender_idle;
      stall_pct = receiver_stall;
      first = requests_accepted;
      while (requests_accepted - first < count) begin
         choice = $urandom_range(99);
         if (choice < 70) begin
            op = acc_cpu_pkg::opcode_type'($urandom_range(15));
            case ($urandom_range(3))
               0:       arg = 12'($urandom_range(acc_cpu_pkg::REG_COUNT + 1));
               1:       arg = 12'($urandom);
               default: arg = {4'($urandom_range(1) * 15), 8'($urandom_range(1) * 255)};
            endcase
            // Move the bank often so banked accesses reach every bank and wrap.
            if (op == acc_cpu_pkg::OP_STORE_REG && $urandom_range(1) == 0) begin
               arg = 12'(acc_cpu_pkg::REG_BANK);
            end
            run_instruction(op, arg);
         end else if (choice < 85) begin
            load_byte(16'($urandom), 8'($urandom));
         end else begin
            step_once();
         end
      end
   endtask

   // Response side: random back-pressure.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Compares each accepted response with the oldest predicted state.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_states.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest_state = pending_states.pop_front();
            check_field("accumulator_value", 16'(rsp_data.accumulator_value),
                        16'(oldest_state.accumulator_value));
            check_field("carry_flag", 16'(rsp_data.carry_flag),
                        16'(oldest_state.carry_flag));
            check_field("next_ip", rsp_data.next_ip, oldest_state.next_ip);
            check_field("io_value", 16'(rsp_data.io_value), 16'(oldest_state.io_value));
            check_field("io_changed", 16'(rsp_data.io_changed),
                        16'(oldest_state.io_changed));
         end
         responses_seen++;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      foreach (mem_image[a]) mem_image[a] = 8'h00;
      foreach (reg_image[r]) reg_image[r] = 8'h00;
      reg_image[acc_cpu_pkg::REG_BANK] = 8'h01;
      acc_model   = 8'h00;
      ip_model    = 16'h0000;
      carry_model = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_every_opcode();
      test_bank_wrap();
      test_random_programs(348, 0, 0);
      test_random_programs(348, 55, 0);
      test_random_programs(348, 0, 55);
      test_random_programs(348, 18, 18);

      // Drain the responses still in flight, then watch for strays.
      req_valid <= 1'b0;
      while (pending_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### accumulator_cpu_step_top.f
sv/acc_cpu_pkg.sv
sv/accumulator_cpu_step_top.sv
dv/tb_accumulator_cpu_step_top.sv
